// ===== hw/rtl/itoa_pkg.sv =====
// Shared types, constants and helpers for the integer to ASCII converter.
package itoa_pkg;

  localparam int DEFAULT_VALUE_WIDTH = 32;

  localparam int BASE_W        = 5;
  localparam int DIGIT_W       = 4;
  localparam int CHAR_W        = 8;
  localparam int LEN_W         = 6;
  localparam int OUT_TDATA_W   = 16;
  localparam int STEP_BITS     = 8;

  localparam logic [BASE_W-1:0] BASE_MIN   = 5'd2;
  localparam logic [BASE_W-1:0] BASE_MAX   = 5'd16;
  localparam logic [BASE_W-1:0] BASE_RESET = 5'd10;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

  localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

  typedef struct packed {
    logic              err;
    logic              neg;
    logic [BASE_W-1:0] base;
  } itoa_cls_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_TEN) begin
      c = CH_ZERO + CHAR_W'(d);
    end else begin
      c = CH_UPPER_A + CHAR_W'(d - DIGIT_TEN);
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/itoa_front.sv =====
// Front end: base register, input acceptance and sign/magnitude classification.
module itoa_front #(
  parameter int VALUE_WIDTH = itoa_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [itoa_pkg::BASE_W-1:0]    cfg_wr_data,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [VALUE_WIDTH-1:0]         in_value,
  output logic                           push,
  input  logic                           q_full,
  output logic [VALUE_WIDTH-1:0]         push_mag,
  output itoa_pkg::itoa_cls_t            push_cls
);

  logic [itoa_pkg::BASE_W-1:0] base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= itoa_pkg::BASE_RESET;
    end else if (cfg_wr_en) begin
      base_r <= cfg_wr_data;
    end
  end

  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  always_comb begin
    push_cls.base = base_r;
    push_cls.err  = (base_r < itoa_pkg::BASE_MIN) || (base_r > itoa_pkg::BASE_MAX);
    push_cls.neg  = in_value[VALUE_WIDTH-1];
    push_mag      = push_cls.neg ? (~in_value + VALUE_WIDTH'(1)) : in_value;
  end

endmodule

// ===== hw/rtl/itoa_fifo.sv =====
// Two-entry queue between the front end and the converter.
module itoa_fifo #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [DATA_W-1:0] wr_data,
  output logic              full,
  input  logic              rd_en,
  output logic              rd_valid,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem_r [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        cnt_r;
  logic              do_wr;
  logic              do_rd;

  assign full     = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_rd) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

// ===== hw/rtl/itoa_back.sv =====
// Back end: chunked restoring divide by the base, digit stack and text output.
module itoa_back #(
  parameter int VALUE_WIDTH = itoa_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_valid,
  output logic                                 q_pop,
  input  logic [VALUE_WIDTH-1:0]               q_mag,
  input  itoa_pkg::itoa_cls_t                  q_cls,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [itoa_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                 out_tlast,
  output logic                                 out_tuser
);

  localparam int SB     = itoa_pkg::STEP_BITS;
  localparam int NCHUNK = (VALUE_WIDTH + SB - 1) / SB;
  localparam int PADW   = NCHUNK * SB;
  localparam int CW     = $clog2(VALUE_WIDTH + 1);
  localparam int KW     = $clog2(NCHUNK + 1);
  localparam int DW     = itoa_pkg::DIGIT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SIGN,
    S_DIGIT,
    S_TERM,
    S_ERR
  } state_t;

  state_t                             state_r;
  logic [PADW-1:0]                    work_r;
  logic [DW-1:0]                      rem_r;
  logic [KW-1:0]                      chunk_r;
  logic [CW-1:0]                      count_r;
  logic [CW-1:0]                      left_r;
  logic                               neg_r;
  logic [itoa_pkg::BASE_W-1:0]        base_r;
  logic [DW-1:0]                      dig_r [VALUE_WIDTH];
  logic                               out_valid_r;
  logic [itoa_pkg::CHAR_W-1:0]        out_char_r;
  logic [itoa_pkg::LEN_W-1:0]         out_len_r;
  logic                               out_last_r;
  logic                               out_err_r;

  logic [PADW-1:0]                    work_nxt;
  logic [DW-1:0]                      rem_nxt;
  logic [SB-1:0]                      q_bits;
  logic                               out_free;
  logic                               emit;
  logic [CW:0]                        len_sum;

  always_comb begin
    logic [DW-1:0]                 r;
    logic [itoa_pkg::BASE_W-1:0]   t;
    r      = rem_r;
    q_bits = '0;
    for (int i = 0; i < SB; i++) begin
      t = {r, work_r[PADW-1-i]};
      if (t >= base_r) begin
        q_bits[SB-1-i] = 1'b1;
        t              = t - base_r;
      end
      r = t[DW-1:0];
    end
    rem_nxt  = r;
    work_nxt = (work_r << SB) | PADW'(q_bits);
  end

  assign q_pop    = (state_r == S_IDLE) && q_valid;
  assign out_free = !out_valid_r || out_tready;
  assign emit     = out_free && ((state_r == S_SIGN) || (state_r == S_DIGIT) ||
                                 (state_r == S_TERM) || (state_r == S_ERR));
  assign len_sum  = (CW+1)'(neg_r) + (CW+1)'(count_r) + (CW+1)'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            work_r  <= PADW'(q_mag);
            rem_r   <= '0;
            chunk_r <= '0;
            count_r <= '0;
            neg_r   <= q_cls.neg;
            base_r  <= q_cls.base;
            state_r <= q_cls.err ? S_ERR : S_DIV;
          end
        end
        S_DIV: begin
          work_r <= work_nxt;
          if (chunk_r == KW'(NCHUNK - 1)) begin
            chunk_r <= '0;
            rem_r   <= '0;
            count_r <= count_r + CW'(1);
            left_r  <= count_r + CW'(1);
            dig_r[0] <= rem_nxt;
            for (int k = 1; k < VALUE_WIDTH; k++) begin
              dig_r[k] <= dig_r[k-1];
            end
            if ((work_nxt == '0) || (count_r == CW'(VALUE_WIDTH - 1))) begin
              state_r <= neg_r ? S_SIGN : S_DIGIT;
            end
          end else begin
            chunk_r <= chunk_r + KW'(1);
            rem_r   <= rem_nxt;
          end
        end
        S_SIGN: begin
          if (out_free) begin
            out_char_r  <= itoa_pkg::CH_MINUS;
            out_len_r   <= '0;
            out_last_r  <= 1'b0;
            out_err_r   <= 1'b0;
            state_r     <= S_DIGIT;
          end
        end
        S_DIGIT: begin
          if (out_free) begin
            out_char_r  <= itoa_pkg::digit_char(dig_r[0]);
            out_len_r   <= '0;
            out_last_r  <= 1'b0;
            out_err_r   <= 1'b0;
            for (int k = 0; k < VALUE_WIDTH - 1; k++) begin
              dig_r[k] <= dig_r[k+1];
            end
            left_r <= left_r - CW'(1);
            if (left_r == CW'(1)) begin
              state_r <= S_TERM;
            end
          end
        end
        S_TERM: begin
          if (out_free) begin
            out_char_r  <= itoa_pkg::CH_NUL;
            out_len_r   <= itoa_pkg::LEN_W'(len_sum);
            out_last_r  <= 1'b1;
            out_err_r   <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        S_ERR: begin
          if (out_free) begin
            out_char_r  <= itoa_pkg::CH_NUL;
            out_len_r   <= '0;
            out_last_r  <= 1'b1;
            out_err_r   <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_len_r, out_char_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

endmodule

// ===== hw/rtl/integer_to_ascii_radix.sv =====
// Each digit comes from the 8-bit-per-cycle restoring divide loop over ceil(VALUE_WIDTH/8) chunks
// of the value (4 at 32 bits); then one character is sent per cycle while the receiver is ready.
// An invalid base gives one error transfer.
// Reset: synchronous active-low; clears control state and sets the base to 10.
// Top level: signed integer to ASCII text in a configurable base from 2 to 16.
module integer_to_ascii_radix #(
  parameter int VALUE_WIDTH = itoa_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [itoa_pkg::BASE_W-1:0]           cfg_wr_data,  // number_base
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]      in_tdata,     // value
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [itoa_pkg::OUT_TDATA_W-1:0]      out_tdata,    // character, text_length
  output logic                                  out_tlast,    // last
  output logic                                  out_tuser     // base_error
);

  localparam int QW = VALUE_WIDTH + $bits(itoa_pkg::itoa_cls_t);

  logic                         push;
  logic                         q_full;
  logic [VALUE_WIDTH-1:0]       push_mag;
  itoa_pkg::itoa_cls_t          push_cls;
  logic                         q_valid;
  logic                         q_pop;
  logic [QW-1:0]                q_data;
  logic [VALUE_WIDTH-1:0]       q_mag;
  itoa_pkg::itoa_cls_t          q_cls;

  itoa_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_value    (in_tdata[VALUE_WIDTH-1:0]),
    .push        (push),
    .q_full      (q_full),
    .push_mag    (push_mag),
    .push_cls    (push_cls)
  );

  itoa_fifo #(.DATA_W(QW)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (push),
    .wr_data  ({push_cls, push_mag}),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_data)
  );

  assign q_mag = q_data[VALUE_WIDTH-1:0];
  assign q_cls = q_data[QW-1:VALUE_WIDTH];

  itoa_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_mag      (q_mag),
    .q_cls      (q_cls),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("error transfer without tlast");

  a_nul_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[7:0] == itoa_pkg::CH_NUL) |-> out_tlast)
    else $error("NUL character before end of text");

  a_len_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> (out_tdata[13:8] == '0))
    else $error("nonzero length on a non-final transfer");

  a_last_is_nul: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> (out_tdata[7:0] == itoa_pkg::CH_NUL))
    else $error("final transfer is not a terminator");

endmodule

// ===== test/itoa_text_checker.sv =====
// Checker for the integer to ASCII converter: predicts the character stream and compares it.
module itoa_text_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [itoa_pkg::BASE_W-1:0]      cfg_wr_data,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [31:0]                      in_tdata,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [itoa_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             out_tlast,
  input  logic                             out_tuser,
  output int                               fail_count,
  output int                               pending
);

  typedef struct packed {
    logic [itoa_pkg::CHAR_W-1:0] character;
    logic                        last;
    logic [itoa_pkg::LEN_W-1:0]  text_length;
    logic                        base_error;
  } text_char_t;

  text_char_t                  expected_chars[$];
  logic [itoa_pkg::BASE_W-1:0] radix_q;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    fail_count++;
  endtask

  function automatic text_char_t make_char(input logic [itoa_pkg::CHAR_W-1:0] c,
                                           input logic l,
                                           input logic [itoa_pkg::LEN_W-1:0] n,
                                           input logic e);
    text_char_t t;
    t.character   = c;
    t.last        = l;
    t.text_length = n;
    t.base_error  = e;
    return t;
  endfunction

  // One value's text: sign if negative, digits msd first, length NUL; bad base: error NUL.
  function automatic void predict_text(input logic [31:0] value,
                                       input logic [itoa_pkg::BASE_W-1:0] radix);
    logic [31:0]                  quot;
    logic [itoa_pkg::DIGIT_W-1:0] digits[32];
    logic [itoa_pkg::DIGIT_W-1:0] d;
    logic [itoa_pkg::CHAR_W-1:0]  c;
    int                           ndig;
    logic                         neg;
    if (radix < itoa_pkg::BASE_MIN || radix > itoa_pkg::BASE_MAX) begin
      expected_chars.push_back(make_char(itoa_pkg::CH_NUL, 1'b1, '0, 1'b1));
      return;
    end
    neg  = value[31];
    quot = neg ? (32'd0 - value) : value;
    ndig = 0;
    do begin
      digits[ndig] = itoa_pkg::DIGIT_W'(quot % radix);
      quot         = quot / radix;
      ndig++;
    end while (quot != 0);
    if (neg) begin
      expected_chars.push_back(make_char(itoa_pkg::CH_MINUS, 1'b0, '0, 1'b0));
    end
    for (int i = ndig - 1; i >= 0; i--) begin
      d = digits[i];
      c = (d < 4'd10) ? itoa_pkg::CH_ZERO + itoa_pkg::CHAR_W'(d)
                      : itoa_pkg::CH_UPPER_A + itoa_pkg::CHAR_W'(d) - 8'd10;
      expected_chars.push_back(make_char(c, 1'b0, '0, 1'b0));
    end
    expected_chars.push_back(make_char(itoa_pkg::CH_NUL, 1'b1,
                                       itoa_pkg::LEN_W'(ndig + 1 + int'(neg)), 1'b0));
  endfunction

  always @(posedge clk) begin
    text_char_t exp_c;
    text_char_t got_c;
    if (!rst_n) begin
      radix_q = itoa_pkg::BASE_RESET;
      expected_chars.delete();
      pending <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_c = make_char(out_tdata[7:0], out_tlast, out_tdata[13:8], out_tuser);
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected output transfer char=%02h", got_c.character));
        end else begin
          exp_c = expected_chars.pop_front();
          if (got_c.character !== exp_c.character)
            report_mismatch($sformatf("character %02h, expected %02h",
                                      got_c.character, exp_c.character));
          if (got_c.last !== exp_c.last)
            report_mismatch($sformatf("last %b, expected %b", got_c.last, exp_c.last));
          if (got_c.text_length !== exp_c.text_length)
            report_mismatch($sformatf("text_length %0d, expected %0d",
                                      got_c.text_length, exp_c.text_length));
          if (got_c.base_error !== exp_c.base_error)
            report_mismatch($sformatf("base_error %b, expected %b",
                                      got_c.base_error, exp_c.base_error));
        end
      end
      if (in_tvalid && in_tready) begin
        predict_text(in_tdata, radix_q);
      end
      if (cfg_wr_en) begin
        radix_q = cfg_wr_data;
      end
      pending <= expected_chars.size();
    end
  end

endmodule

// ===== test/integer_to_ascii_radix_tb.sv =====
// Testbench top for the integer to ASCII converter: stimulus, flow control and verdict.
module integer_to_ascii_radix_tb;

  localparam int VALUE_W      = 32;
  localparam int TIMEOUT      = 12_000_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 36;
  localparam int NUM_PHASES   = 12;
  localparam int TAIL_CYCLES  = 200;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             cfg_wr_en = 1'b0;
  logic [itoa_pkg::BASE_W-1:0]      cfg_wr_data = '0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [VALUE_W-1:0]               in_tdata = '0;    // value
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [itoa_pkg::OUT_TDATA_W-1:0] out_tdata;        // character, text_length
  logic                             out_tlast;        // last
  logic                             out_tuser;        // base_error

  int   fail_count;
  int   pending;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic hold_go = 1'b0;
  logic hold_active = 1'b0;

  integer_to_ascii_radix #(.VALUE_WIDTH(VALUE_W)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  itoa_text_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #TIMEOUT;
    $display("Test completed with failures");
    $finish;
  end

  // long receiver hold-off so the converter backs up into its input
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_active = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active = 1'b0;
  end

  always @(negedge clk) begin
    if (hold_active) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 55; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 55; end
      default:   begin send_idle_pct = 24; recv_stall_pct = 24; end
    endcase
  endtask

  task automatic send_value(input logic [VALUE_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // base changes only once every pending character has been transferred
  task automatic set_base(input logic [itoa_pkg::BASE_W-1:0] radix);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= radix;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    int                 k;
    k = $urandom_range(0, 31);
    case ($urandom_range(0, 7))
      0: v = $urandom_range(0, 40);
      1: v = 32'd0 - $urandom_range(1, 40);
      2: v = 32'd1 << k;
      3: v = (32'd1 << k) - 32'd1;
      4: v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: v = $urandom();
    endcase
    if (k[0] && $urandom_range(0, 1)) begin
      v = 32'd0 - v;
    end
    return v;
  endfunction

  initial begin
    logic [VALUE_W-1:0]          dec_cases[9];
    logic [VALUE_W-1:0]          bin_cases[3];
    logic [VALUE_W-1:0]          hex_cases[3];
    logic [itoa_pkg::BASE_W-1:0] phase_base[NUM_PHASES];
    dec_cases  = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'd9, 32'd10, 32'hFFFF_FFF6, 32'd1_000_000_000};
    bin_cases  = '{32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF};
    hex_cases  = '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0FED_CBA9};
    phase_base = '{5'd2, 5'd10, 5'd16, 5'd7, 5'd0, 5'd3, 5'd13, 5'd1,
                   5'd8, 5'd17, 5'd31, 5'd5};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    set_idling(IDLE_NONE);

    // reset base of ten first, then the radix extremes and invalid settings
    foreach (dec_cases[i]) send_value(dec_cases[i]);
    set_base(5'd2);
    foreach (bin_cases[i]) send_value(bin_cases[i]);
    set_base(5'd16);
    foreach (hex_cases[i]) send_value(hex_cases[i]);
    set_base(5'd0);
    send_value(32'd123);
    set_base(5'd31);
    send_value(32'hFFFF_FF85);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_base(phase_base[ph]);
      set_idling(idle_mode_t'(ph % 4));
      if (ph == 8) begin
        hold_go = 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_value(random_value());
      end
    end

    in_tvalid <= 1'b0;
    set_idling(IDLE_NONE);
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/itoa_pkg.sv
hw/rtl/itoa_front.sv
hw/rtl/itoa_fifo.sv
hw/rtl/itoa_back.sv
hw/rtl/integer_to_ascii_radix.sv
test/itoa_text_checker.sv
test/integer_to_ascii_radix_tb.sv
